>>> hdl/spq_pkg.sv
// Package for the sorted priority queue: shared widths, operation codes
// and the control struct that travels from the top level to each cell.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic push;   // insert the broadcast value this cycle
        logic pop;    // shift every entry one place towards the head
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> hdl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: chain of spq_cell instances,
// entry counter and registered result stage.
// Depends on spq_pkg and spq_cell.
`default_nettype none

// Ascending priority queue of signed 32-bit values held in sorted order in a
// row of QUEUE_DEPTH cells. A push (tuser = 0) inserts tdata ahead of every
// stored entry greater than or equal to it, so the newest of equal values
// leaves first; a pop (tuser = 1) removes the smallest entry. Every input
// transaction yields exactly one output transaction carrying the popped
// value, a valid flag, an empty flag (pop on an empty queue), a full flag
// (push dropped because the queue was full) and the occupancy after the
// operation, low five bits only. One transaction is taken per clock while
// tready is high: each cell compares its entry with the broadcast value and
// looks only at its left neighbour's flag, so an insert or a pop completes
// in the cycle it is accepted and its result goes into the output register.
// The sustained rate is set by the output register alone: tready drops only
// while a result is held and not taken. Stored entries have no reset; the
// counter alone says which cells hold data.
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire  [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] popped_value, [36:32] occupancy
    output logic [2:0]  m_axis_tuser    // [0] popped_valid, [1] empty_error,
                                        // [2] full_error
);
    import spq_pkg::*;

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cell_ctl                 cell_ctl;
    logic signed [DATA_W-1:0]  in_value;
    logic                      accept;
    logic                      is_pop;
    logic                      do_push;
    logic                      do_pop;
    logic                      is_full;
    logic                      is_empty;

    logic        [QUEUE_DEPTH-1:0] cell_flag;
    logic signed [DATA_W-1:0]      cell_data [QUEUE_DEPTH];

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [31:0]        count_ext;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_popped_value;
    logic [OCC_W-1:0]  r_occupancy;
    logic              r_popped_valid;
    logic              r_empty_error;
    logic              r_full_error;

    // accept whenever the output register is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pop        = (t_op'(s_axis_tuser[0]) == OP_POP);
    assign in_value      = s_axis_tdata;

    assign is_full  = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);
    assign do_push  = accept && !is_pop && !is_full;
    assign do_pop   = accept && is_pop && !is_empty;

    assign cell_ctl.push = do_push;
    assign cell_ctl.pop  = do_pop;

    // chain of cells; head of the queue sits in cell 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_cell #(
            .IDX     (g),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_value      (in_value),
            .i_count      (r_count),
            .i_left_flag  ((g == 0) ? 1'b0 : cell_flag[(g == 0) ? 0 : g - 1]),
            .i_left_data  (cell_data[(g == 0) ? 0 : g - 1]),
            .i_right_data (cell_data[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .o_flag       (cell_flag[g]),
            .o_data       (cell_data[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + COUNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    assign count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: hold until the next accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped_value <= do_pop ? cell_data[0] : '0;
            r_popped_valid <= do_pop;
            r_empty_error  <= is_pop && is_empty;
            r_full_error   <= !is_pop && is_full;
            r_occupancy    <= count_ext[OCC_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_occupancy, r_popped_value};
    assign m_axis_tuser  = {r_full_error, r_empty_error, r_popped_valid};

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_push_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> r_count == $past(r_count) + COUNT_W'(1))
        else $error("accepted push did not grow the count");

    a_pop_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> r_count == $past(r_count) - COUNT_W'(1))
        else $error("accepted pop did not shrink the count");

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones(m_axis_tuser) <= 1)
        else $error("more than one result flag set");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty_error) |-> (r_popped_value == '0 && r_occupancy == '0))
        else $error("empty pop reported data or occupancy");

endmodule

`default_nettype wire

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain: holds a single entry and decides
// its next value from its own compare, its left flag and its neighbours.
// Depends on spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int IDX     = 0,
    parameter int COUNT_W = 5
) (
    input  wire                              i_clk,
    input  wire spq_pkg::t_cell_ctl          i_ctl,
    input  wire signed [spq_pkg::DATA_W-1:0] i_value,
    input  wire        [COUNT_W-1:0]         i_count,
    input  wire                              i_left_flag,
    input  wire signed [spq_pkg::DATA_W-1:0] i_left_data,
    input  wire signed [spq_pkg::DATA_W-1:0] i_right_data,
    output logic                             o_flag,
    output logic signed [spq_pkg::DATA_W-1:0] o_data
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     occupied;

    // an empty cell counts as holding plus infinity, so flags stay monotonic
    assign occupied = COUNT_W'(IDX) < i_count;
    assign o_flag   = !occupied || (r_data >= i_value);
    assign o_data   = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push && o_flag) begin
            // first flagged cell takes the new value, the rest shift right
            n_data = i_left_flag ? i_left_data : i_value;
        end else if (i_ctl.pop) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

>>> dv/spq_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted priority queue: keeps its own sorted copy of the
// queue, predicts one result per input transaction and compares each output one.
// Depends on spq_pkg.
module spq_checker #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [31:0] i_s_tdata,     // [31:0] value
    input  wire  [0:0]  i_s_tuser,     // [0] op
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [39:0] i_m_tdata,     // [31:0] popped_value, [36:32] occupancy
    input  wire  [2:0]  i_m_tuser,     // [0] popped_valid, [1] empty_error, [2] full_error
    output int          o_mismatches,
    output int          o_outstanding
);
    import spq_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] popped_value;
        logic              popped_valid;
        logic              empty_error;
        logic              full_error;
        logic [OCC_W-1:0]  occupancy;
    } t_queue_result;

    logic signed [DATA_W-1:0] sorted_copy [QUEUE_DEPTH];
    int                       stored_count;
    t_queue_result            pending_results [$];

    // Insert ahead of the first entry >= value, or remove the head.
    function automatic t_queue_result apply_operation(t_op op, logic signed [DATA_W-1:0] value);
        t_queue_result res;
        int            pos;
        res = '0;
        if (op == OP_PUSH) begin
            if (stored_count >= QUEUE_DEPTH) begin
                res.full_error = 1'b1;
            end else begin
                pos = 0;
                while (pos < stored_count && sorted_copy[pos] < value)
                    pos++;
                for (int i = stored_count; i > pos; i--)
                    sorted_copy[i] = sorted_copy[i - 1];
                sorted_copy[pos] = value;
                stored_count++;
            end
        end else begin
            if (stored_count == 0) begin
                res.empty_error = 1'b1;
            end else begin
                res.popped_value = sorted_copy[0];
                res.popped_valid = 1'b1;
                for (int i = 1; i < stored_count; i++)
                    sorted_copy[i - 1] = sorted_copy[i];
                stored_count--;
            end
        end
        res.occupancy = stored_count[OCC_W-1:0];
        return res;
    endfunction

    function automatic void note_failure(string what);
        if (o_mismatches < 10)
            $display("%0t: %s", $realtime, what);
        o_mismatches++;
    endfunction

    function automatic string describe(t_queue_result r);
        return $sformatf("value=%0d valid=%b empty=%b full=%b occ=%0d",
                         $signed(r.popped_value), r.popped_valid, r.empty_error,
                         r.full_error, r.occupancy);
    endfunction

    always @(posedge i_clk) begin
        t_queue_result observed;
        t_queue_result predicted;
        if (!i_rst_n) begin
            stored_count = 0;
            pending_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(apply_operation(t_op'(i_s_tuser[0]), i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                observed.popped_value = i_m_tdata[31:0];
                observed.occupancy    = i_m_tdata[36:32];
                observed.popped_valid = i_m_tuser[0];
                observed.empty_error  = i_m_tuser[1];
                observed.full_error   = i_m_tuser[2];
                if (pending_results.size() == 0) begin
                    note_failure({"result with nothing outstanding: ", describe(observed)});
                end else begin
                    predicted = pending_results.pop_front();
                    if (observed != predicted)
                        note_failure({"mismatch: expected ", describe(predicted),
                                      " got ", describe(observed)});
                end
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
// Depends on spq_pkg, sorted_priority_queue_core and spq_checker.
module testbench;

    import spq_pkg::*;

    localparam int CLK_HALF      = 4;      // 8 ns period
    localparam int RESET_CYCLES  = 7;
    localparam int PHASE_ITEMS   = 150;    // four idling phases, about 600 items
    localparam int BIAS_SPAN     = 40;     // items between push/pop bias flips
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;   // cycles without any transaction

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;            // [31:0] value
    logic [0:0]  s_tuser  = '0;            // [0] op
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;                  // [31:0] popped_value, [36:32] occupancy
    wire  [2:0]  m_tuser;                  // [0] popped_valid, [1] empty_error,
                                           // [2] full_error

    int idle_pct     = 0;                  // chance per cycle that the sender holds off
    int stall_pct    = 0;                  // chance per cycle that the receiver stalls
    int quiet_cycles = 0;
    int mismatches;
    int outstanding;

    sorted_priority_queue_core #(
        .QUEUE_DEPTH (DEFAULT_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    spq_checker #(
        .QUEUE_DEPTH (DEFAULT_DEPTH)
    ) queue_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Receiver: decide each cycle's tready on the falling edge so that it is
    // settled well before the block samples it.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: count cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one transaction. Called on a falling edge and returns on the
    // falling edge after it is taken, so tvalid stays high between
    // back-to-back transactions and is never dropped and raised in one step.
    task automatic offer(t_op op, logic [31:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mix of small values (many ties), the extremes, and full-range noise.
    function automatic logic [31:0] pick_value();
        int unsigned pick;
        pick = $urandom_range(7);
        case (pick)
            0, 1: begin
                return $urandom_range(4) - 2;
            end
            2: begin
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Alternate push-heavy and pop-heavy stretches so that the queue keeps
    // running all the way up to full and back down to empty.
    task automatic random_run(int items);
        int push_pct;
        push_pct = 75;
        for (int n = 0; n < items; n++) begin
            if (n % BIAS_SPAN == 0)
                push_pct = ((n / BIAS_SPAN) % 2 == 0) ? 75 : 25;
            offer(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, pick_value());
        end
    endtask

    initial begin
        logic [31:0] fill_values [16];
        int          phase_idle  [4];
        int          phase_stall [4];
        bit          timed_out;

        // Sixteen pushes fill the queue: both extremes, zero, minus one,
        // repeated minimum and maximum, and a run of equal values.
        fill_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'h0000_0001, 32'h8000_0000, 32'h0000_0007, 32'h0000_0007,
                        32'h0000_0007, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd7,
                        32'h7FFF_FFFF, 32'h0000_0064, -32'sd100,    32'h0000_0000};
        phase_idle  = '{0, 49, 0, 15};
        phase_stall = '{0, 0, 49, 15};

        fork
            begin
                repeat (RESET_CYCLES) @(posedge i_clk);
                @(negedge i_clk);
                i_rst_n <= 1'b1;
                @(negedge i_clk);

                // Directed part: pop while empty, fill to the brim, push
                // into a full queue (a small positive and a minimum value,
                // both dropped), drain a little, refill one place, pop again.
                offer(OP_POP, $urandom());
                foreach (fill_values[i])
                    offer(OP_PUSH, fill_values[i]);
                offer(OP_PUSH, 32'h0000_002A);
                offer(OP_PUSH, 32'h8000_0000);
                repeat (3) offer(OP_POP, $urandom());
                offer(OP_PUSH, 32'h0000_0001);
                offer(OP_POP, 32'h0000_0000);

                // Random part, one stretch per idling phase.
                for (int p = 0; p < 4; p++) begin
                    idle_pct  = phase_idle[p];
                    stall_pct = phase_stall[p];
                    random_run(PHASE_ITEMS);
                end
                s_tvalid  <= 1'b0;
                stall_pct = 0;

                // Drain: every transaction must come back before the verdict.
                wait (outstanding == 0);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                wait (quiet_cycles >= QUIET_LIMIT);
            end
        join_any

        timed_out = (quiet_cycles >= QUIET_LIMIT);
        if (!timed_out && mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
